// ===== hdl/four_wheel_steer_reference_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-wheel steering reference core
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FOUR_WHEEL_STEER_REFERENCE_CORE_ASSERT_SVH
`define FOUR_WHEEL_STEER_REFERENCE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FWSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FWSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fwsr_pkg.sv =====
// ----------------------------------------------------------------------------
// fwsr_pkg
// Shared constants, types and tables of the four-wheel steering reference.
// ----------------------------------------------------------------------------
package fwsr_pkg;

    // CORDIC depth, capped by the arctangent table
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_CORDIC    = 24;
    localparam int CORDIC_USED   = (CORDIC_STAGES > MAX_CORDIC) ? MAX_CORDIC : CORDIC_STAGES;

    // Square root: 28 result bits, two bits per stage
    localparam int SQ_BITS = 28;
    localparam int SQ_STG  = SQ_BITS / 2;
    localparam int NW      = 2 * SQ_BITS;
    localparam int RW      = 30;

    // Stage counts
    localparam int CORE_STG = (CORDIC_USED > SQ_STG) ? CORDIC_USED : SQ_STG;
    localparam int KIN_STG  = 3;
    localparam int LANE_STG = CORE_STG + 4;
    localparam int PIPE_STG = KIN_STG + LANE_STG;

    // Datapath widths
    localparam int VW = 48;
    localparam int CW = 50;
    localparam int ZW = 35;
    localparam int BIG_SHIFT = 39;

    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

    typedef logic signed [VW-1:0] vel_t;

    // Configuration register indexes
    typedef enum logic {
        REG_HALF_LENGTH = 1'b0,
        REG_HALF_WIDTH  = 1'b1
    } cfg_reg_t;

    // State of one wheel lane in the CORDIC / square-root section
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [NW-1:0]        rad;
        logic [RW-1:0]        rem;
        logic [SQ_BITS-1:0]   root;
        logic                 neg;
        logic                 big;
        logic                 spec;
        logic signed [15:0]   spec_ang;
    } core_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd843314856;
            5'd1:    r = 30'd497837829;
            5'd2:    r = 30'd263043836;
            5'd3:    r = 30'd133525158;
            5'd4:    r = 30'd67021686;
            5'd5:    r = 30'd33543515;
            5'd6:    r = 30'd16775850;
            5'd7:    r = 30'd8388437;
            5'd8:    r = 30'd4194282;
            5'd9:    r = 30'd2097149;
            5'd10:   r = 30'd1048575;
            5'd11:   r = 30'd524287;
            5'd12:   r = 30'd262143;
            5'd13:   r = 30'd131071;
            5'd14:   r = 30'd65535;
            5'd15:   r = 30'd32767;
            5'd16:   r = 30'd16383;
            5'd17:   r = 30'd8191;
            5'd18:   r = 30'd4095;
            5'd19:   r = 30'd2047;
            5'd20:   r = 30'd1023;
            5'd21:   r = 30'd511;
            5'd22:   r = 30'd255;
            5'd23:   r = 30'd127;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/fwsr_if.sv =====
// ----------------------------------------------------------------------------
// fwsr_if
// Valid/ready channels for reference samples and wheel commands.
// ----------------------------------------------------------------------------
interface fwsr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ref_speed;
    logic signed [15:0] ref_curvature;

    modport source (output valid, ref_speed, ref_curvature, input ready);
    modport sink   (input valid, ref_speed, ref_curvature, output ready);
endinterface

interface fwsr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_rear_left;
    logic signed [15:0] speed_rear_right;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] angle_front_left;
    logic signed [15:0] angle_rear_left;
    logic signed [15:0] angle_rear_right;
    logic signed [15:0] angle_front_right;

    modport source (output valid, speed_front_left, speed_rear_left, speed_rear_right,
                    speed_front_right, angle_front_left, angle_rear_left,
                    angle_rear_right, angle_front_right, input ready);
    modport sink   (input valid, speed_front_left, speed_rear_left, speed_rear_right,
                    speed_front_right, angle_front_left, angle_rear_left,
                    angle_rear_right, angle_front_right, output ready);
endinterface

// ===== hdl/fwsr_kin.sv =====
// ----------------------------------------------------------------------------
// fwsr_kin
// Yaw rate and per-wheel velocity components, three register stages.
// ----------------------------------------------------------------------------
module fwsr_kin (
    input  logic                      clk,
    input  logic [fwsr_pkg::KIN_STG-1:0] en,
    input  logic signed [15:0]        ref_speed,
    input  logic signed [15:0]        ref_curvature,
    input  logic [14:0]               half_length,
    input  logic [14:0]               half_width,
    output fwsr_pkg::vel_t            vx [4],
    output fwsr_pkg::vel_t            vy [4]
);

    logic signed [31:0] w_reg;
    logic signed [15:0] v1_reg;
    logic signed [15:0] v2_reg;
    fwsr_pkg::vel_t     lw_reg;
    fwsr_pkg::vel_t     ww_reg;
    fwsr_pkg::vel_t     vbase;
    fwsr_pkg::vel_t     vx_reg [4];
    fwsr_pkg::vel_t     vy_reg [4];

    // Stage 1: yaw rate w = v * k
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            w_reg  <= 32'(ref_speed) * 32'(ref_curvature);
            v1_reg <= ref_speed;
        end
    end

    // Stage 2: wheel offsets times yaw rate
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            lw_reg <= fwsr_pkg::vel_t'($signed({1'b0, half_length})) * fwsr_pkg::vel_t'(w_reg);
            ww_reg <= fwsr_pkg::vel_t'($signed({1'b0, half_width})) * fwsr_pkg::vel_t'(w_reg);
            v2_reg <= v1_reg;
        end
    end

    // Stage 3: vx = v - y*w, vy = x*w per wheel
    assign vbase = fwsr_pkg::vel_t'(v2_reg) <<< 24;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            vx_reg[0] <= vbase - ww_reg;
            vx_reg[1] <= vbase - ww_reg;
            vx_reg[2] <= vbase + ww_reg;
            vx_reg[3] <= vbase + ww_reg;
            vy_reg[0] <= lw_reg;
            vy_reg[1] <= -lw_reg;
            vy_reg[2] <= -lw_reg;
            vy_reg[3] <= lw_reg;
        end
    end

    assign vx = vx_reg;
    assign vy = vy_reg;

endmodule

// ===== hdl/fwsr_lane.sv =====
// ----------------------------------------------------------------------------
// fwsr_lane
// One wheel: pipelined square root for speed, pipelined CORDIC for angle.
// ----------------------------------------------------------------------------
module fwsr_lane (
    input  logic                          clk,
    input  logic [fwsr_pkg::LANE_STG-1:0] en,
    input  fwsr_pkg::vel_t                vx,
    input  fwsr_pkg::vel_t                vy,
    output logic signed [15:0]            speed,
    output logic signed [15:0]            angle
);

    localparam int SB = fwsr_pkg::SQ_BITS;
    localparam int CS = fwsr_pkg::CORE_STG;

    logic [SB-1:0]       ax20_reg, ay20_reg, ax20_next, ay20_next;
    fwsr_pkg::core_t     prep_reg, prep_next;
    logic [2*SB-1:0]     sqx_reg, sqy_reg;
    fwsr_pkg::core_t     sq_hold_reg;
    fwsr_pkg::core_t     seed_next;
    fwsr_pkg::core_t     c_reg [CS+1];
    logic signed [15:0]  speed_reg, angle_reg, speed_next, angle_next;

    // One digit-by-digit square root step
    function automatic fwsr_pkg::core_t sqrt_step(input fwsr_pkg::core_t c);
        fwsr_pkg::core_t   r;
        logic [fwsr_pkg::RW+1:0] r_in;
        logic [fwsr_pkg::RW+1:0] trial;
        r     = c;
        r_in  = {c.rem, c.rad[fwsr_pkg::NW-1 -: 2]};
        trial = (fwsr_pkg::RW+2)'({c.root, 2'b01});
        r.rad = c.rad << 2;
        if (r_in >= trial)
        begin
            r.rem  = fwsr_pkg::RW'(r_in - trial);
            r.root = {c.root[SB-2:0], 1'b1};
        end
        else
        begin
            r.rem  = fwsr_pkg::RW'(r_in);
            r.root = {c.root[SB-2:0], 1'b0};
        end
        return r;
    endfunction

    // Prep stage: rounding, magnitudes, range check, CORDIC start, special cases
    always_comb
    begin
        fwsr_pkg::vel_t abs_x, abs_y, x20, y20;
        abs_x = vx[fwsr_pkg::VW-1] ? -vx : vx;
        abs_y = vy[fwsr_pkg::VW-1] ? -vy : vy;
        x20   = (vx + fwsr_pkg::vel_t'(2048)) >>> 12;
        y20   = (vy + fwsr_pkg::vel_t'(2048)) >>> 12;
        ax20_next = x20[fwsr_pkg::VW-1] ? SB'(-x20) : SB'(x20);
        ay20_next = y20[fwsr_pkg::VW-1] ? SB'(-y20) : SB'(y20);

        prep_next      = '0;
        prep_next.neg  = vx[fwsr_pkg::VW-1];
        prep_next.big  = (|abs_x[fwsr_pkg::VW-1:fwsr_pkg::BIG_SHIFT])
                      || (|abs_y[fwsr_pkg::VW-1:fwsr_pkg::BIG_SHIFT]);
        if (vx[fwsr_pkg::VW-1])
        begin
            prep_next.x = fwsr_pkg::CW'(-vx);
            prep_next.y = fwsr_pkg::CW'(-vy);
            prep_next.z = vy[fwsr_pkg::VW-1] ? -fwsr_pkg::PI_Q30 : fwsr_pkg::PI_Q30;
        end
        else
        begin
            prep_next.x = fwsr_pkg::CW'(vx);
            prep_next.y = fwsr_pkg::CW'(vy);
            prep_next.z = '0;
        end

        // Horizontal vector: zero or pi. Vertical vector: plus or minus pi/2.
        if (vy == '0)
        begin
            prep_next.spec     = 1'b1;
            prep_next.spec_ang = vx[fwsr_pkg::VW-1] ? fwsr_pkg::PI_Q13 : 16'sd0;
        end
        else if (vx == '0)
        begin
            prep_next.spec     = 1'b1;
            prep_next.spec_ang = vy[fwsr_pkg::VW-1] ? -fwsr_pkg::HALF_PI_Q13
                                                    : fwsr_pkg::HALF_PI_Q13;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ax20_reg <= ax20_next;
            ay20_reg <= ay20_next;
            prep_reg <= prep_next;
        end
    end

    // Square the rounded components
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sqx_reg     <= (2*SB)'(ax20_reg) * (2*SB)'(ax20_reg);
            sqy_reg     <= (2*SB)'(ay20_reg) * (2*SB)'(ay20_reg);
            sq_hold_reg <= prep_reg;
        end
    end

    // Sum of squares seeds the root
    always_comb
    begin
        seed_next      = sq_hold_reg;
        seed_next.rad  = sqx_reg + sqy_reg;
        seed_next.rem  = '0;
        seed_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_reg[0] <= seed_next;
        end
    end

    // Core stages: one micro-rotation each below CORDIC_USED, two root bits each below SQ_STG
    for (genvar i = 0; i < CS; i++)
    begin : g_core
        fwsr_pkg::core_t      nxt;
        logic signed [fwsr_pkg::CW-1:0] xs, ys;
        logic signed [fwsr_pkg::ZW-1:0] da;

        always_comb
        begin
            nxt = c_reg[i];
            xs  = c_reg[i].x >>> i;
            ys  = c_reg[i].y >>> i;
            da  = $signed({5'b0, fwsr_pkg::atan_q30(5'(i))});
            if (i < fwsr_pkg::CORDIC_USED)
            begin
                if (!c_reg[i].y[fwsr_pkg::CW-1])
                begin
                    nxt.x = c_reg[i].x + ys;
                    nxt.y = c_reg[i].y - xs;
                    nxt.z = c_reg[i].z + da;
                end
                else
                begin
                    nxt.x = c_reg[i].x - ys;
                    nxt.y = c_reg[i].y + xs;
                    nxt.z = c_reg[i].z - da;
                end
            end
            if (i < fwsr_pkg::SQ_STG)
            begin
                nxt = sqrt_step(sqrt_step(nxt));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[3+i])
            begin
                c_reg[i+1] <= nxt;
            end
        end
    end

    // Final stage: round, saturate and clamp
    always_comb
    begin
        logic [SB:0]                    rnd;
        logic [16:0]                    s;
        logic signed [fwsr_pkg::ZW-1:0] zr;
        rnd = {1'b0, c_reg[CS].root} + (SB+1)'(2048);
        s   = rnd[SB -: 17];
        zr  = (c_reg[CS].z + fwsr_pkg::ZW'(65536)) >>> 17;

        if (c_reg[CS].big)
        begin
            speed_next = c_reg[CS].neg ? 16'sh8000 : 16'sh7fff;
        end
        else if (c_reg[CS].neg)
        begin
            speed_next = (s > 17'd32768) ? 16'sh8000 : 16'(-s);
        end
        else
        begin
            speed_next = (s > 17'd32767) ? 16'sh7fff : 16'(s);
        end

        if (c_reg[CS].spec)
        begin
            angle_next = c_reg[CS].spec_ang;
        end
        else if (zr > fwsr_pkg::ZW'(fwsr_pkg::PI_Q13))
        begin
            angle_next = fwsr_pkg::PI_Q13;
        end
        else if (zr < -fwsr_pkg::ZW'(fwsr_pkg::PI_Q13))
        begin
            angle_next = -fwsr_pkg::PI_Q13;
        end
        else
        begin
            angle_next = 16'(zr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[CS+3])
        begin
            speed_reg <= speed_next;
            angle_reg <= angle_next;
        end
    end

    assign speed = speed_reg;
    assign angle = angle_reg;

endmodule

// ===== hdl/four_wheel_steer_reference_core.sv =====
// ----------------------------------------------------------------------------
// four_wheel_steer_reference_core: wheel speeds and steer angles from v and k
// Core length is the larger of the CORDIC depth and the square-root stages.
// Throughput: one sample per cycle unless result.ready stalls the output.
// Reset clears both geometry registers and all pipeline valid bits at once.
// ----------------------------------------------------------------------------
`include "four_wheel_steer_reference_core_assert.svh"

module four_wheel_steer_reference_core (
    input  logic              clk,
    input  logic              rst_n,
    fwsr_in_if.sink           sample,
    fwsr_out_if.source        result,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [14:0]       cfg_data
);

    localparam int NS = fwsr_pkg::PIPE_STG;
    localparam int KS = fwsr_pkg::KIN_STG;

    logic [14:0]          half_length_reg, half_width_reg;
    logic [NS-1:0]        valid_reg, en;
    fwsr_pkg::vel_t       vx [4];
    fwsr_pkg::vel_t       vy [4];
    logic signed [15:0]   speed_w [4];
    logic signed [15:0]   angle_w [4];

    // Geometry registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= '0;
            half_width_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (fwsr_pkg::cfg_reg_t'(cfg_index))
                fwsr_pkg::REG_HALF_LENGTH: half_length_reg <= cfg_data;
                fwsr_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || result.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= sample.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign sample.ready = en[0];
    assign result.valid = valid_reg[NS-1];

    fwsr_kin u_kin (
        .clk           (clk),
        .en            (en[KS-1:0]),
        .ref_speed     (sample.ref_speed),
        .ref_curvature (sample.ref_curvature),
        .half_length   (half_length_reg),
        .half_width    (half_width_reg),
        .vx            (vx),
        .vy            (vy)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        fwsr_lane u_lane (
            .clk   (clk),
            .en    (en[NS-1:KS]),
            .vx    (vx[g]),
            .vy    (vy[g]),
            .speed (speed_w[g]),
            .angle (angle_w[g])
        );
    end

    assign result.speed_front_left  = speed_w[0];
    assign result.speed_rear_left   = speed_w[1];
    assign result.speed_rear_right  = speed_w[2];
    assign result.speed_front_right = speed_w[3];
    assign result.angle_front_left  = angle_w[0];
    assign result.angle_rear_left   = angle_w[1];
    assign result.angle_rear_right  = angle_w[2];
    assign result.angle_front_right = angle_w[3];

    // Checks
    `FWSR_ASSERT_NEXT(a_accept_enters, clk, rst_n, sample.valid && sample.ready, valid_reg[0], "accepted request did not enter the pipeline")
    `FWSR_ASSERT_NOW(a_stall_full, clk, rst_n, !sample.ready, valid_reg == '1, "input stalled while a pipeline stage is empty")
    `FWSR_ASSERT_NOW(a_angle_range, clk, rst_n, result.valid, (result.angle_front_left <= fwsr_pkg::PI_Q13) && (result.angle_front_left >= -fwsr_pkg::PI_Q13), "front-left angle out of range")

endmodule
